@@ sv/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, constants and helpers of the stereo feedback delay.
// ----------------------------------------------------------------------------
package sfd_pkg;

	// Fixed formats
	localparam int SAMPLE_BITS    = 24;
	localparam int DATA_W         = 32;
	localparam int COEF_W         = 16;
	localparam int MULC_W         = 18;
	localparam int PROD_W         = DATA_W + MULC_W;
	localparam int TIME_FRAC      = 14;
	localparam int TIME_UNIT_BITS = 28;
	localparam int DT_W           = 30;
	localparam int CFG_W          = 64;
	localparam int CFG_IDX_W      = 3;
	localparam int STEP_W         = 5;

	// Defaults of the top-level parameters
	localparam int RING_DEPTH_DEF = 65536;
	localparam int COEF_FRAC_DEF  = 14;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_TIME,
		REG_INPUT_FILTER,
		REG_LOOP_GAINS,
		REG_FADE,
		REG_DAMP_LOW,
		REG_DAMP_HIGH
	} cfg_reg_t;

	// Sequencer phases
	typedef enum logic [2:0] {
		PH_CLEAR,
		PH_IDLE,
		PH_FRONT,
		PH_COMMON,
		PH_BACK,
		PH_WRITE,
		PH_DONE
	} sfd_phase_t;

	typedef struct packed {
		logic                          route_change;
		logic signed [SAMPLE_BITS-1:0] sample_left;
		logic signed [SAMPLE_BITS-1:0] sample_right;
	} sfd_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_left;
		logic signed [SAMPLE_BITS-1:0] out_right;
		logic                          overrun;
	} sfd_out_t;

	// One operation of the shared multiply / add unit
	typedef struct packed {
		logic                     mul_en;
		logic                     mul_tf;
		logic signed [DATA_W-1:0] mul_a;
		logic signed [MULC_W-1:0] mul_c;
		logic signed [DATA_W-1:0] alu_a;
		logic signed [DATA_W-1:0] alu_b;
		logic                     alu_sub;
	} sfd_op_t;

	// Saturate an internal word to the sample width
	function automatic logic [SAMPLE_BITS-1:0] sat_smp(input logic signed [DATA_W-1:0] v);
		logic [SAMPLE_BITS-1:0] r;
		if ((&v[DATA_W-1:SAMPLE_BITS-1]) || ~(|v[DATA_W-1:SAMPLE_BITS-1])) begin
			r = v[SAMPLE_BITS-1:0];
		end else if (v[DATA_W-1]) begin
			r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
		return r;
	endfunction

	// Coefficient word n of a register, sign extended to the operand width
	function automatic logic signed [MULC_W-1:0] cw(input logic [CFG_W-1:0] r, input int n);
		logic [COEF_W-1:0] w;
		w = r[COEF_W*n +: COEF_W];
		return {{(MULC_W-COEF_W){w[COEF_W-1]}}, w};
	endfunction

endpackage

@@ sv/stereo_feedback_delay_effect.sv @@
// ----------------------------------------------------------------------------
// stereo_feedback_delay_effect
// Stereo feedback delay with glided delay time and interpolated tap.
// ----------------------------------------------------------------------------
// After reset the block sweeps both delay rings to zero, one entry a cycle;
// configuration writes are taken throughout but no sample item is accepted
// until the sweep ends. Each stereo item then runs every filter, fade, glide
// and mix operation in turn through one shared multiplier and one
// saturating adder (13 steps per channel for the input filter, 10 common
// steps for fade and glide, 29 steps per channel for the tap, damping and
// output mix, plus accept, ring write and hand-over). The result sits in an
// output register, so the next item is accepted while it waits.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_effect import sfd_pkg::*; #(
	parameter int RING_DEPTH     = RING_DEPTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 smp_valid,
	output logic                 smp_ready,
	input  sfd_in_t              smp,
	output logic                 res_valid,
	input  logic                 res_ready,
	output sfd_out_t             res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int AW  = $clog2(RING_DEPTH);
	localparam int IPW = 22;
	localparam int FSH = TIME_UNIT_BITS - COEF_FRAC_BITS;
	localparam int FW  = DATA_W + 16;

	localparam logic [STEP_W-1:0] FRONT_LAST  = STEP_W'(12);
	localparam logic [STEP_W-1:0] COMMON_LAST = STEP_W'(9);
	localparam logic [STEP_W-1:0] BACK_LAST   = STEP_W'(28);

	localparam logic signed [MULC_W-1:0] ONE_C   = MULC_W'(2**COEF_FRAC_BITS);
	localparam logic signed [DATA_W-1:0] ONE_W   = DATA_W'(2**COEF_FRAC_BITS);
	localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// sequencer
	sfd_phase_t         phase_q, phase_d;
	logic [STEP_W-1:0]  step_q, step_d;
	logic               ch_q, ch_d;
	logic [AW-1:0]      clr_q;
	logic [AW-1:0]      wp_q;

	// configuration
	logic [DT_W-1:0]    dt_q;
	logic [CFG_W-1:0]   filt_q, gain_q, fade_q, dlo_q, dhi_q;

	// per-channel state
	logic signed [DATA_W-1:0] band_q [2];
	logic signed [DATA_W-1:0] low_q  [2];
	logic signed [DATA_W-1:0] fbt_q  [2];
	logic signed [DATA_W-1:0] lp_q   [2];
	logic signed [DATA_W-1:0] hp_q   [2];
	logic signed [DATA_W-1:0] dc_q   [2];

	// shared state
	logic signed [MULC_W-1:0] fade_level_q;
	logic signed [DATA_W-1:0] fade_sum_q;
	logic signed [DATA_W-1:0] sm_q;
	logic [DT_W-1:0]          prev_tgt_q;
	logic signed [DATA_W-1:0] glide_q;
	logic                     ovf_q;
	logic                     out_valid_q;

	// working registers
	sfd_in_t                  in_q;
	logic signed [MULC_W-1:0] fz_q;
	logic signed [DATA_W-1:0] tmp_a_q, tmp_b_q, tmp_c_q;
	logic [SAMPLE_BITS-1:0]   rin_q [2];
	logic [SAMPLE_BITS-1:0]   res_q [2];
	logic                     gt_q;
	logic [AW-1:0]            a1_q;
	logic [TIME_FRAC-1:0]     fr_q;
	sfd_out_t                 out_q;

	// datapath signals
	sfd_op_t                  op;
	logic signed [DATA_W-1:0] mul_y, alu_y;
	logic signed [DATA_W-1:0] x_w, rd_w, tt_w, v_w, abs_w, fclamp_w, sm_w;
	logic signed [MULC_W-1:0] c_r, c_g, c_mix, c_on, c_fb, c_mute, c_dry, c_wet;
	logic signed [MULC_W-1:0] c_fk, c_fgain, c_fup, c_fdn, c_k1, c_lpg, c_lfd, c_hpg;
	logic signed [MULC_W-1:0] c_k2, c_hfd, c_dcg, c_slew;
	logic signed [FW-1:0]     fs_w, tp_w;
	logic                     fs_ge;
	logic [IPW-1:0]           ip_w;
	logic [TIME_FRAC-1:0]     fr_w;
	logic                     ovr_w;
	logic [AW:0]              sum1_w;
	logic [AW-1:0]            a1_w, a2_w, wp_new_w, ring_addr;
	logic                     ring_we;
	logic [SAMPLE_BITS-1:0]   wd0, wd1, rd0, rd1;
	logic                     go_out;

	// coefficient words
	assign c_r     = cw(filt_q, 0);
	assign c_g     = cw(filt_q, 1);
	assign c_mix   = cw(filt_q, 2);
	assign c_on    = cw(filt_q, 3);
	assign c_fb    = cw(gain_q, 0);
	assign c_mute  = cw(gain_q, 1);
	assign c_dry   = cw(gain_q, 2);
	assign c_wet   = cw(gain_q, 3);
	assign c_fk    = cw(fade_q, 0);
	assign c_fgain = cw(fade_q, 1);
	assign c_fup   = cw(fade_q, 2);
	assign c_fdn   = cw(fade_q, 3);
	assign c_k1    = cw(dlo_q, 0);
	assign c_lpg   = cw(dlo_q, 1);
	assign c_lfd   = cw(dlo_q, 2);
	assign c_hpg   = cw(dlo_q, 3);
	assign c_k2    = cw(dhi_q, 0);
	assign c_hfd   = cw(dhi_q, 1);
	assign c_dcg   = cw(dhi_q, 2);
	assign c_slew  = cw(dhi_q, 3);

	assign cfg_ready = 1'b1;
	assign smp_ready = (phase_q == PH_IDLE);
	assign res_valid = out_valid_q;
	assign res       = out_q;
	assign go_out    = (phase_q == PH_DONE) && (!out_valid_q || res_ready);

	// channel sample, ring read data and target time
	assign x_w  = ch_q ? DATA_W'($signed(in_q.sample_right)) : DATA_W'($signed(in_q.sample_left));
	assign rd_w = ch_q ? DATA_W'($signed(rd1)) : DATA_W'($signed(rd0));
	assign tt_w = DATA_W'({2'b00, dt_q});

	// fade step choice: fade sum in time units against the previous glide
	assign fs_w  = FW'(mul_y) <<< FSH;
	assign tp_w  = FW'(sm_q);
	assign fs_ge = (fs_w >= tp_w);

	// clamp the new fade level to [0, one]
	always_comb begin
		if (alu_y < 0) begin
			fclamp_w = '0;
		end else if (alu_y > ONE_W) begin
			fclamp_w = ONE_W;
		end else begin
			fclamp_w = alu_y;
		end
	end

	// glide distance and its saturated magnitude
	always_comb begin
		v_w = (dt_q != prev_tgt_q) ? tmp_a_q : glide_q;
		if (v_w == INT_MIN) begin
			abs_w = INT_MAX;
		end else if (v_w < 0) begin
			abs_w = -v_w;
		end else begin
			abs_w = v_w;
		end
	end

	// move toward the target without passing it
	always_comb begin
		if (gt_q) begin
			sm_w = (alu_y > tt_w) ? tt_w : alu_y;
		end else begin
			sm_w = (alu_y < tt_w) ? tt_w : alu_y;
		end
	end

	// tap position, overrun saturation and first ring address
	always_comb begin
		if (sm_q[DATA_W-1]) begin
			ip_w = '0;
			fr_w = '0;
		end else begin
			ip_w = IPW'(sm_q[DATA_W-2:TIME_FRAC]);
			fr_w = sm_q[TIME_FRAC-1:0];
		end
		ovr_w = ((ip_w + IPW'(2)) >= IPW'(RING_DEPTH));
		if (ovr_w) begin
			ip_w = IPW'(RING_DEPTH - 3);
			fr_w = '0;
		end
		sum1_w = {1'b0, wp_q} + {1'b0, ip_w[AW-1:0]} + (AW+1)'(1);
		if (sum1_w >= (AW+1)'(RING_DEPTH)) begin
			a1_w = AW'(sum1_w - (AW+1)'(RING_DEPTH));
		end else begin
			a1_w = sum1_w[AW-1:0];
		end
	end

	// ring addressing
	assign a2_w     = (a1_q == AW'(RING_DEPTH - 1)) ? '0 : a1_q + AW'(1);
	assign wp_new_w = (wp_q == '0) ? AW'(RING_DEPTH - 1) : wp_q - AW'(1);

	always_comb begin
		ring_we   = 1'b0;
		ring_addr = a1_q;
		wd0       = '0;
		wd1       = '0;
		case (phase_q)
			PH_CLEAR: begin
				ring_we   = 1'b1;
				ring_addr = clr_q;
			end
			PH_WRITE: begin
				ring_we   = 1'b1;
				ring_addr = wp_new_w;
				wd0       = rin_q[0];
				wd1       = rin_q[1];
			end
			PH_BACK: begin
				if (step_q == STEP_W'(1)) begin
					ring_addr = a2_w;
				end
			end
			default: begin
				ring_addr = a1_q;
			end
		endcase
	end

	sfd_ring #(.RING_DEPTH(RING_DEPTH)) u_ring_left (
		.clk   (clk),
		.we    (ring_we),
		.addr  (ring_addr),
		.wdata (wd0),
		.rdata (rd0)
	);

	sfd_ring #(.RING_DEPTH(RING_DEPTH)) u_ring_right (
		.clk   (clk),
		.we    (ring_we),
		.addr  (ring_addr),
		.wdata (wd1),
		.rdata (rd1)
	);

	sfd_arith #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_arith (
		.clk   (clk),
		.op    (op),
		.mul_y (mul_y),
		.alu_y (alu_y)
	);

	// next phase, step and channel
	always_comb begin
		phase_d = phase_q;
		step_d  = step_q;
		ch_d    = ch_q;
		case (phase_q)
			PH_CLEAR: begin
				if (clr_q == AW'(RING_DEPTH - 1)) begin
					phase_d = PH_IDLE;
				end
			end
			PH_IDLE: begin
				if (smp_valid) begin
					phase_d = PH_FRONT;
					step_d  = '0;
					ch_d    = 1'b0;
				end
			end
			PH_FRONT: begin
				if (step_q == FRONT_LAST) begin
					step_d = '0;
					ch_d   = ~ch_q;
					if (ch_q) begin
						phase_d = PH_COMMON;
					end
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			PH_COMMON: begin
				if (step_q == COMMON_LAST) begin
					step_d  = '0;
					ch_d    = 1'b0;
					phase_d = PH_BACK;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			PH_BACK: begin
				if (step_q == BACK_LAST) begin
					step_d = '0;
					ch_d   = ~ch_q;
					if (ch_q) begin
						phase_d = PH_WRITE;
					end
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			PH_WRITE: begin
				phase_d = PH_DONE;
			end
			PH_DONE: begin
				if (go_out) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// operands of the shared unit for each step
	always_comb begin
		op = '0;
		case (phase_q)
			PH_FRONT: begin
				case (step_q)
					STEP_W'(0): begin
						op.mul_en = 1'b1; op.mul_a = band_q[ch_q]; op.mul_c = c_r;
					end
					STEP_W'(1): begin
						op.alu_a = x_w; op.alu_b = mul_y; op.alu_sub = 1'b1;
						op.mul_en = 1'b1; op.mul_a = band_q[ch_q]; op.mul_c = c_g;
					end
					STEP_W'(2): begin
						op.alu_a = mul_y; op.alu_b = low_q[ch_q];
					end
					STEP_W'(3): begin
						op.alu_a = tmp_a_q; op.alu_b = low_q[ch_q]; op.alu_sub = 1'b1;
					end
					STEP_W'(4): begin
						op.mul_en = 1'b1; op.mul_a = tmp_c_q; op.mul_c = c_g;
					end
					STEP_W'(5): begin
						op.alu_a = mul_y; op.alu_b = band_q[ch_q];
						op.mul_en = 1'b1; op.mul_a = tmp_b_q; op.mul_c = c_mix;
					end
					STEP_W'(6): begin
						op.mul_en = 1'b1; op.mul_a = x_w; op.mul_c = ONE_C - c_mix;
					end
					STEP_W'(7): begin
						op.alu_a = tmp_a_q; op.alu_b = mul_y;
					end
					STEP_W'(8): begin
						op.mul_en = 1'b1; op.mul_a = tmp_a_q; op.mul_c = c_on;
					end
					STEP_W'(9): begin
						op.mul_en = 1'b1; op.mul_a = fbt_q[ch_q]; op.mul_c = c_fb;
					end
					STEP_W'(10): begin
						op.alu_a = tmp_a_q; op.alu_b = mul_y;
					end
					STEP_W'(11): begin
						op.mul_en = 1'b1; op.mul_a = tmp_a_q; op.mul_c = c_mute;
					end
					default: begin
						op = '0;
					end
				endcase
			end
			PH_COMMON: begin
				case (step_q)
					STEP_W'(0): begin
						op.alu_a = DATA_W'(c_fk); op.alu_b = fade_sum_q;
					end
					STEP_W'(1): begin
						op.mul_en = 1'b1; op.mul_a = tmp_a_q; op.mul_c = c_fgain;
					end
					STEP_W'(2): begin
						op.alu_a = DATA_W'(fz_q);
						op.alu_b = fs_ge ? DATA_W'(c_fup) : DATA_W'(c_fdn);
					end
					STEP_W'(3): begin
						op.mul_en = 1'b1; op.mul_a = tmp_b_q; op.mul_c = c_mute;
					end
					STEP_W'(5): begin
						op.alu_a = tt_w; op.alu_b = sm_q; op.alu_sub = 1'b1;
					end
					STEP_W'(7): begin
						op.mul_en = 1'b1; op.mul_a = tmp_a_q; op.mul_c = c_slew;
					end
					STEP_W'(8): begin
						op.alu_a = sm_q; op.alu_b = mul_y; op.alu_sub = ~gt_q;
					end
					default: begin
						op = '0;
					end
				endcase
			end
			PH_BACK: begin
				case (step_q)
					STEP_W'(2): begin
						op.alu_a = rd_w; op.alu_b = tmp_a_q; op.alu_sub = 1'b1;
					end
					STEP_W'(3): begin
						op.mul_en = 1'b1; op.mul_tf = 1'b1; op.mul_a = tmp_b_q;
						op.mul_c = MULC_W'({1'b0, fr_q});
					end
					STEP_W'(4): begin
						op.alu_a = tmp_a_q; op.alu_b = mul_y;
					end
					STEP_W'(5): begin
						op.mul_en = 1'b1; op.mul_a = tmp_a_q; op.mul_c = fz_q;
					end
					STEP_W'(7): begin
						op.alu_a = tmp_c_q; op.alu_b = lp_q[ch_q]; op.alu_sub = 1'b1;
					end
					STEP_W'(8): begin
						op.mul_en = 1'b1; op.mul_a = tmp_a_q; op.mul_c = c_k1;
					end
					STEP_W'(9): begin
						op.mul_en = 1'b1; op.mul_a = tmp_a_q; op.mul_c = c_lpg;
					end
					STEP_W'(10): begin
						op.alu_a = mul_y; op.alu_b = lp_q[ch_q];
					end
					STEP_W'(11): begin
						op.mul_en = 1'b1; op.mul_a = lp_q[ch_q]; op.mul_c = c_lfd;
					end
					STEP_W'(12): begin
						op.alu_a = tmp_b_q; op.alu_b = mul_y; op.alu_sub = 1'b1;
					end
					STEP_W'(13): begin
						op.alu_a = tmp_b_q; op.alu_b = hp_q[ch_q]; op.alu_sub = 1'b1;
					end
					STEP_W'(14): begin
						op.mul_en = 1'b1; op.mul_a = tmp_b_q; op.mul_c = c_hpg;
					end
					STEP_W'(15): begin
						op.alu_a = mul_y; op.alu_b = hp_q[ch_q];
					end
					STEP_W'(16): begin
						op.mul_en = 1'b1; op.mul_a = hp_q[ch_q]; op.mul_c = c_k2;
					end
					STEP_W'(17): begin
						op.mul_en = 1'b1; op.mul_a = tmp_b_q; op.mul_c = c_hfd;
					end
					STEP_W'(18): begin
						op.alu_a = tmp_a_q; op.alu_b = mul_y; op.alu_sub = 1'b1;
					end
					STEP_W'(19): begin
						op.alu_a = tmp_a_q; op.alu_b = dc_q[ch_q]; op.alu_sub = 1'b1;
					end
					STEP_W'(20): begin
						op.mul_en = 1'b1; op.mul_a = tmp_a_q; op.mul_c = c_dcg;
					end
					STEP_W'(21): begin
						op.alu_a = mul_y; op.alu_b = dc_q[ch_q];
					end
					STEP_W'(22): begin
						op.mul_en = 1'b1; op.mul_a = x_w; op.mul_c = c_dry;
					end
					STEP_W'(24): begin
						op.mul_en = 1'b1; op.mul_a = tmp_b_q; op.mul_c = c_on;
					end
					STEP_W'(25): begin
						op.mul_en = 1'b1; op.mul_a = x_w; op.mul_c = ONE_C - c_on;
					end
					STEP_W'(26): begin
						op.alu_a = tmp_b_q; op.alu_b = mul_y;
						op.mul_en = 1'b1; op.mul_a = tmp_c_q; op.mul_c = c_wet;
					end
					STEP_W'(27): begin
						op.alu_a = tmp_b_q; op.alu_b = mul_y;
					end
					default: begin
						op = '0;
					end
				endcase
			end
			default: begin
				op = '0;
			end
		endcase
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CLEAR;
			step_q  <= '0;
			ch_q    <= 1'b0;
		end else begin
			phase_q <= phase_d;
			step_q  <= step_d;
			ch_q    <= ch_d;
		end
	end

	// configuration and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			wp_q         <= '0;
			dt_q         <= '0;
			filt_q       <= '0;
			gain_q       <= '0;
			fade_q       <= '0;
			dlo_q        <= '0;
			dhi_q        <= '0;
			band_q       <= '{default: '0};
			low_q        <= '{default: '0};
			fbt_q        <= '{default: '0};
			lp_q         <= '{default: '0};
			hp_q         <= '{default: '0};
			dc_q         <= '{default: '0};
			fade_level_q <= '0;
			fade_sum_q   <= '0;
			sm_q         <= '0;
			prev_tgt_q   <= '0;
			glide_q      <= '0;
			ovf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// register writes; unknown indexes drop
			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					REG_DELAY_TIME:   dt_q   <= cfg_data[DT_W-1:0];
					REG_INPUT_FILTER: filt_q <= cfg_data;
					REG_LOOP_GAINS:   gain_q <= cfg_data;
					REG_FADE:         fade_q <= cfg_data;
					REG_DAMP_LOW:     dlo_q  <= cfg_data;
					REG_DAMP_HIGH:    dhi_q  <= cfg_data;
					default: begin
						dt_q <= dt_q;
					end
				endcase
			end

			// advance the clearing sweep
			if (phase_q == PH_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end

			// route change restarts the fade sum
			if (smp_valid && smp_ready && smp.route_change) begin
				fade_sum_q <= '0;
			end

			if (phase_q == PH_FRONT) begin
				if (step_q == STEP_W'(5)) begin
					band_q[ch_q] <= alu_y;
					low_q[ch_q]  <= tmp_b_q;
				end
			end

			if (phase_q == PH_COMMON) begin
				case (step_q)
					STEP_W'(2): fade_sum_q   <= mul_y;
					STEP_W'(4): fade_level_q <= mul_y[MULC_W-1:0];
					STEP_W'(6): begin
						glide_q    <= v_w;
						prev_tgt_q <= dt_q;
					end
					STEP_W'(8): sm_q <= sm_w;
					STEP_W'(9): begin
						if (ovr_w) begin
							ovf_q <= 1'b1;
						end
					end
					default: begin
						ovf_q <= ovf_q;
					end
				endcase
			end

			if (phase_q == PH_BACK) begin
				case (step_q)
					STEP_W'(10): lp_q[ch_q]  <= alu_y;
					STEP_W'(15): hp_q[ch_q]  <= alu_y;
					STEP_W'(19): fbt_q[ch_q] <= alu_y;
					STEP_W'(21): dc_q[ch_q]  <= alu_y;
					default: begin
						ovf_q <= ovf_q;
					end
				endcase
			end

			// step the write position back once per item
			if (phase_q == PH_WRITE) begin
				wp_q <= wp_new_w;
			end

			// result register: load when free or being taken
			if (go_out) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (smp_valid && smp_ready) begin
			in_q <= smp;
			fz_q <= smp.route_change ? '0 : fade_level_q;
		end

		case (phase_q)
			PH_FRONT: begin
				case (step_q)
					STEP_W'(1):  tmp_a_q <= alu_y;
					STEP_W'(2):  tmp_b_q <= alu_y;
					STEP_W'(3):  tmp_c_q <= alu_y;
					STEP_W'(6):  tmp_a_q <= mul_y;
					STEP_W'(7):  tmp_a_q <= alu_y;
					STEP_W'(9):  tmp_a_q <= mul_y;
					STEP_W'(10): tmp_a_q <= alu_y;
					STEP_W'(12): rin_q[ch_q] <= sat_smp(mul_y);
					default: begin
						tmp_a_q <= tmp_a_q;
					end
				endcase
			end
			PH_COMMON: begin
				case (step_q)
					STEP_W'(0): tmp_a_q <= alu_y;
					STEP_W'(2): tmp_b_q <= fclamp_w;
					STEP_W'(5): begin
						tmp_a_q <= alu_y;
						gt_q    <= (alu_y > 0);
					end
					STEP_W'(6): tmp_a_q <= abs_w;
					STEP_W'(9): begin
						a1_q <= a1_w;
						fr_q <= fr_w;
					end
					default: begin
						tmp_a_q <= tmp_a_q;
					end
				endcase
			end
			PH_BACK: begin
				case (step_q)
					STEP_W'(1):  tmp_a_q <= rd_w;
					STEP_W'(2):  tmp_b_q <= alu_y;
					STEP_W'(4):  tmp_a_q <= alu_y;
					STEP_W'(6):  tmp_c_q <= mul_y;
					STEP_W'(7):  tmp_a_q <= alu_y;
					STEP_W'(9):  tmp_b_q <= mul_y;
					STEP_W'(12): tmp_b_q <= alu_y;
					STEP_W'(13): tmp_b_q <= alu_y;
					STEP_W'(17): tmp_a_q <= mul_y;
					STEP_W'(18): tmp_a_q <= alu_y;
					STEP_W'(19): tmp_a_q <= alu_y;
					STEP_W'(23): tmp_b_q <= mul_y;
					STEP_W'(25): tmp_b_q <= mul_y;
					STEP_W'(26): tmp_b_q <= alu_y;
					STEP_W'(27): tmp_b_q <= alu_y;
					STEP_W'(28): res_q[ch_q] <= sat_smp(tmp_b_q);
					default: begin
						tmp_a_q <= tmp_a_q;
					end
				endcase
			end
			default: begin
				tmp_a_q <= tmp_a_q;
			end
		endcase

		if (go_out) begin
			out_q.out_left  <= res_q[0];
			out_q.out_right <= res_q[1];
			out_q.overrun   <= ovf_q;
		end
	end

	// an accepted item starts the input filter pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(smp_valid && smp_ready) |=> (phase_q == PH_FRONT))
		else $error("accepted item did not start processing");

	// overrun stays set once seen
	assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q)
		else $error("overrun flag cleared");

	// the write position moves only in the ring write step
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_WRITE) |=> $stable(wp_q))
		else $error("write position moved outside the ring write");

	// a result appears only at hand-over
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(phase_q) == PH_DONE))
		else $error("result raised outside hand-over");

	// tap address stays inside the ring
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BACK) |-> (a1_q <= AW'(RING_DEPTH - 1)))
		else $error("tap address beyond ring");

endmodule

@@ sv/sfd_arith.sv @@
// ----------------------------------------------------------------------------
// sfd_arith
// Shared arithmetic unit: registered coefficient multiply with floor shift
// and saturation, plus a saturating add / subtract.
// ----------------------------------------------------------------------------
module sfd_arith import sfd_pkg::*; #(
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
	input  logic                     clk,
	input  sfd_op_t                  op,
	output logic signed [DATA_W-1:0] mul_y,
	output logic signed [DATA_W-1:0] alu_y
);

	localparam logic signed [PROD_W-1:0] P_MAX = PROD_W'(64'sd2147483647);
	localparam logic signed [PROD_W-1:0] P_MIN = PROD_W'(-64'sd2147483648);

	logic signed [PROD_W-1:0] prod_q;
	logic                     tf_q;
	logic signed [PROD_W-1:0] sh_w;
	logic signed [DATA_W:0]   sum_w;

	// hold the product until the next multiply is issued
	always_ff @(posedge clk) begin
		if (op.mul_en) begin
			prod_q <= $signed(op.mul_a) * $signed(op.mul_c);
			tf_q   <= op.mul_tf;
		end
	end

	// floor shift and saturate the product
	always_comb begin
		sh_w = tf_q ? (prod_q >>> TIME_FRAC) : (prod_q >>> COEF_FRAC_BITS);
		if (sh_w > P_MAX) begin
			mul_y = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (sh_w < P_MIN) begin
			mul_y = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			mul_y = sh_w[DATA_W-1:0];
		end
	end

	// saturating add / subtract
	always_comb begin
		if (op.alu_sub) begin
			sum_w = (DATA_W+1)'($signed(op.alu_a)) - (DATA_W+1)'($signed(op.alu_b));
		end else begin
			sum_w = (DATA_W+1)'($signed(op.alu_a)) + (DATA_W+1)'($signed(op.alu_b));
		end
		if (sum_w[DATA_W] != sum_w[DATA_W-1]) begin
			alu_y = sum_w[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			alu_y = sum_w[DATA_W-1:0];
		end
	end

endmodule

@@ sv/sfd_ring.sv @@
// ----------------------------------------------------------------------------
// sfd_ring
// One channel of the delay ring: single-port memory with registered read.
// ----------------------------------------------------------------------------
module sfd_ring import sfd_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	localparam int AW = $clog2(RING_DEPTH)
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          addr,
	input  logic [SAMPLE_BITS-1:0] wdata,
	output logic [SAMPLE_BITS-1:0] rdata
);

	logic [SAMPLE_BITS-1:0] mem [RING_DEPTH];

	// read one entry a cycle, and write it when enabled
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
